### design/best_fit_box_store_macros.svh
// Assertion macros used by the checker of the box store.
`ifndef BEST_FIT_BOX_STORE_MACROS_SVH
`define BEST_FIT_BOX_STORE_MACROS_SVH

// Same-cycle implication under reset.
`define BFBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box store check failed");

// Next-cycle implication under reset.
`define BFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box store check failed");

`endif

### design/bfbs_pkg.sv
package bfbs_pkg;

  localparam int ID_BITS = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_TAKE_W = 2'd1;
  localparam logic [1:0] OP_TAKE_V = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [ID_BITS-1:0] ID_NONE = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic               active;
    logic [1:0]         op;
    logic               found;
    logic [ID_BITS-1:0] best_id;
  } bfbs_tok_t;

endpackage

### design/best_fit_box_store.sv
// Best-fit box store. Each accepted word (add a box, or take the box whose weight or
// volume is the smallest one at or above a threshold) gives one result word: the
// accepted word is registered, then a search word walks the row of CAPACITY storage
// cells one cell per cycle, and then the result is registered. The block handles one
// word at a time and takes the next input word in the cycle after the result has
// been taken. No clearing pass is needed after reset.
module best_fit_box_store #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_box_weight,
  input  logic [15:0] in_box_volume,
  input  logic [15:0] in_threshold,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_box_id
);
  import bfbs_pkg::*;

  localparam int SLOT_BITS = $clog2(CAPACITY);

  state_t               state_r, state_nxt;
  logic                 launch_r;
  logic [1:0]           op_r;
  logic [KEY_BITS-1:0]  wt_r;
  logic [KEY_BITS-1:0]  vol_r;
  logic [KEY_BITS-1:0]  thr_r;
  logic [ID_BITS-1:0]   serial_r, serial_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic                 in_acc;
  logic                 clr_en;
  bfbs_tok_t            tok   [0:CAPACITY];
  logic [KEY_BITS-1:0]  key   [0:CAPACITY];
  logic [SLOT_BITS-1:0] slot  [0:CAPACITY];
  bfbs_tok_t            tok_last;

  assign in_acc   = in_valid && in_ready;
  assign tok_last = tok[CAPACITY];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SCAN;
      S_SCAN: if (tok_last.active) state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
  end

  always_comb begin
    tok[0].active  = launch_r;
    tok[0].op      = op_r;
    tok[0].found   = 1'b0;
    tok[0].best_id = '0;
    key[0]         = '0;
    slot[0]        = '0;
  end

  always_comb begin
    clr_en     = 1'b0;
    serial_nxt = serial_r;
    status_nxt = ST_NONE;
    id_nxt     = ID_NONE;
    if (tok_last.op == OP_ADD) begin
      if (tok_last.found) begin
        status_nxt = ST_DONE;
        id_nxt     = serial_r;
        serial_nxt = serial_r + 1'b1;
      end else begin
        status_nxt = ST_FULL;
        id_nxt     = '0;
      end
    end else if (((tok_last.op == OP_TAKE_W) || (tok_last.op == OP_TAKE_V)) &&
                 tok_last.found) begin
      status_nxt = ST_DONE;
      id_nxt     = tok_last.best_id;
      clr_en     = tok_last.active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      launch_r <= 1'b0;
      serial_r <= '0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc;
      if (tok_last.active) begin
        serial_r <= serial_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_op;
      wt_r  <= KEY_BITS'({16'd0, in_box_weight});
      vol_r <= KEY_BITS'({16'd0, in_box_volume});
      thr_r <= KEY_BITS'({16'd0, in_threshold});
    end
    if (tok_last.active) begin
      status_r <= status_nxt;
      id_r     <= id_nxt;
    end
  end

  assign out_status = status_r;
  assign out_box_id = id_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bfbs_cell #(
      .KEY_BITS  (KEY_BITS),
      .SLOT_BITS (SLOT_BITS),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_in     (tok[i]),
      .key_in     (key[i]),
      .slot_in    (slot[i]),
      .tok_out    (tok[i+1]),
      .key_out    (key[i+1]),
      .slot_out   (slot[i+1]),
      .cmd_weight (wt_r),
      .cmd_volume (vol_r),
      .cmd_thr    (thr_r),
      .cmd_serial (serial_r),
      .clr_en     (clr_en),
      .clr_slot   (slot[CAPACITY])
    );
  end

endmodule

### design/bfbs_cell.sv
module bfbs_cell #(
  parameter int KEY_BITS  = 16,
  parameter int SLOT_BITS = 4,
  parameter int IDX       = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bfbs_pkg::bfbs_tok_t       tok_in,
  input  logic [KEY_BITS-1:0]       key_in,
  input  logic [SLOT_BITS-1:0]      slot_in,
  output bfbs_pkg::bfbs_tok_t       tok_out,
  output logic [KEY_BITS-1:0]       key_out,
  output logic [SLOT_BITS-1:0]      slot_out,
  input  logic [KEY_BITS-1:0]       cmd_weight,
  input  logic [KEY_BITS-1:0]       cmd_volume,
  input  logic [KEY_BITS-1:0]       cmd_thr,
  input  logic [bfbs_pkg::ID_BITS-1:0] cmd_serial,
  input  logic                      clr_en,
  input  logic [SLOT_BITS-1:0]      clr_slot
);
  import bfbs_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r;
  logic [KEY_BITS-1:0]  wt_r;
  logic [KEY_BITS-1:0]  vol_r;
  bfbs_tok_t            tok_r, tok_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [SLOT_BITS-1:0] slot_r, slot_nxt;
  logic [KEY_BITS-1:0]  key_sel;
  logic                 is_take;
  logic                 claim;
  logic                 better;

  always_comb begin
    is_take = (tok_in.op == OP_TAKE_W) || (tok_in.op == OP_TAKE_V);
    key_sel = (tok_in.op == OP_TAKE_V) ? vol_r : wt_r;
    claim   = tok_in.active && (tok_in.op == OP_ADD) && !tok_in.found && !valid_r;
    better  = tok_in.active && is_take && valid_r && (key_sel >= cmd_thr) &&
              (!tok_in.found || (key_sel < key_in) ||
               ((key_sel == key_in) && (id_r < tok_in.best_id)));
    tok_nxt  = tok_in;
    key_nxt  = key_in;
    slot_nxt = slot_in;
    if (claim) begin
      tok_nxt.found = 1'b1;
    end
    if (better) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.best_id = id_r;
      key_nxt         = key_sel;
      slot_nxt        = SLOT_BITS'(IDX);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (clr_en && (clr_slot == SLOT_BITS'(IDX))) begin
      valid_nxt = 1'b0;
    end else if (claim) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    slot_r <= slot_nxt;
    if (claim) begin
      id_r  <= cmd_serial;
      wt_r  <= cmd_weight;
      vol_r <= cmd_volume;
    end
  end

  assign tok_out  = tok_r;
  assign key_out  = key_r;
  assign slot_out = slot_r;

endmodule

### design/bfbs_checker.sv
`include "best_fit_box_store_macros.svh"

module bfbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic [15:0] in_box_weight,
  input logic [15:0] in_box_volume,
  input logic [15:0] in_threshold,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_box_id
);
  import bfbs_pkg::*;

  `BFBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_box_id))
  `BFBS_ASSERT_NEXT(a_no_early_word, clk, rst_n, in_valid && in_ready, !out_valid && !in_ready)
  `BFBS_ASSERT_NOW(a_none_marker, clk, rst_n, out_valid && (out_status == ST_NONE), out_box_id == ID_NONE)
  `BFBS_ASSERT_NOW(a_full_zero, clk, rst_n, out_valid && (out_status == ST_FULL), out_box_id == 16'd0)
  `BFBS_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, (out_status == ST_DONE) || (out_status == ST_NONE) || (out_status == ST_FULL))

endmodule

bind best_fit_box_store bfbs_checker u_bfbs_checker (.*);
